### rtl/c6502_pkg.sv
// shared types, codes and the opcode decoder of the 6502 instruction core
// used by the controller, datapath and top rtl files; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package c6502_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;

    // request kinds carried in s_tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;
    localparam logic [1:0] KIND_EXEC  = 2'd3;

    // status flag positions
    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [15:0] RESET_VEC = 16'hFFFC;

    // sequencer steps
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MWR   = 5'd1;
    localparam logic [4:0] ST_MRD   = 5'd2;
    localparam logic [4:0] ST_MRD2  = 5'd3;
    localparam logic [4:0] ST_RV0   = 5'd4;
    localparam logic [4:0] ST_RV1   = 5'd5;
    localparam logic [4:0] ST_RV2   = 5'd6;
    localparam logic [4:0] ST_FETCH = 5'd7;
    localparam logic [4:0] ST_DEC   = 5'd8;
    localparam logic [4:0] ST_A1    = 5'd9;
    localparam logic [4:0] ST_A2    = 5'd10;
    localparam logic [4:0] ST_I1    = 5'd11;
    localparam logic [4:0] ST_I2    = 5'd12;
    localparam logic [4:0] ST_J1    = 5'd13;
    localparam logic [4:0] ST_J2    = 5'd14;
    localparam logic [4:0] ST_JS2   = 5'd15;
    localparam logic [4:0] ST_OPRD  = 5'd16;
    localparam logic [4:0] ST_EXEC  = 5'd17;
    localparam logic [4:0] ST_IMPL  = 5'd18;
    localparam logic [4:0] ST_PL2   = 5'd19;
    localparam logic [4:0] ST_T1    = 5'd20;
    localparam logic [4:0] ST_R1    = 5'd21;
    localparam logic [4:0] ST_R2    = 5'd22;
    localparam logic [4:0] ST_DONE  = 5'd23;

    // addressing modes
    localparam logic [3:0] M_IMP  = 4'd0;
    localparam logic [3:0] M_IMM  = 4'd1;
    localparam logic [3:0] M_ZP   = 4'd2;
    localparam logic [3:0] M_ZPX  = 4'd3;
    localparam logic [3:0] M_ZPY  = 4'd4;
    localparam logic [3:0] M_ABS  = 4'd5;
    localparam logic [3:0] M_ABX  = 4'd6;
    localparam logic [3:0] M_ABY  = 4'd7;
    localparam logic [3:0] M_IZX  = 4'd8;
    localparam logic [3:0] M_IZY  = 4'd9;
    localparam logic [3:0] M_REL  = 4'd10;
    localparam logic [3:0] M_JMP  = 4'd11;
    localparam logic [3:0] M_JIND = 4'd12;
    localparam logic [3:0] M_JSR  = 4'd13;

    // operations, grouped so that opcode fields map on by an offset
    localparam logic [5:0] OP_ORA  = 6'd0;
    localparam logic [5:0] OP_AND  = 6'd1;
    localparam logic [5:0] OP_EOR  = 6'd2;
    localparam logic [5:0] OP_ADC  = 6'd3;
    localparam logic [5:0] OP_STA  = 6'd4;
    localparam logic [5:0] OP_LDA  = 6'd5;
    localparam logic [5:0] OP_CMP  = 6'd6;
    localparam logic [5:0] OP_SBC  = 6'd7;
    localparam logic [5:0] OP_STX  = 6'd8;
    localparam logic [5:0] OP_LDX  = 6'd9;
    localparam logic [5:0] OP_DEC  = 6'd10;
    localparam logic [5:0] OP_INC  = 6'd11;
    localparam logic [5:0] OP_ASL  = 6'd12;
    localparam logic [5:0] OP_ROL  = 6'd13;
    localparam logic [5:0] OP_LSR  = 6'd14;
    localparam logic [5:0] OP_ROR  = 6'd15;
    localparam logic [5:0] OP_ASLA = 6'd16;
    localparam logic [5:0] OP_ROLA = 6'd17;
    localparam logic [5:0] OP_LSRA = 6'd18;
    localparam logic [5:0] OP_RORA = 6'd19;
    localparam logic [5:0] OP_TXA  = 6'd20;
    localparam logic [5:0] OP_TAX  = 6'd21;
    localparam logic [5:0] OP_DEX  = 6'd22;
    localparam logic [5:0] OP_NOP  = 6'd23;
    localparam logic [5:0] OP_TXS  = 6'd24;
    localparam logic [5:0] OP_TSX  = 6'd25;
    localparam logic [5:0] OP_PHP  = 6'd26;
    localparam logic [5:0] OP_PLP  = 6'd27;
    localparam logic [5:0] OP_PHA  = 6'd28;
    localparam logic [5:0] OP_PLA  = 6'd29;
    localparam logic [5:0] OP_DEY  = 6'd30;
    localparam logic [5:0] OP_TAY  = 6'd31;
    localparam logic [5:0] OP_INY  = 6'd32;
    localparam logic [5:0] OP_INX  = 6'd33;
    localparam logic [5:0] OP_CLC  = 6'd34;
    localparam logic [5:0] OP_SEC  = 6'd35;
    localparam logic [5:0] OP_CLI  = 6'd36;
    localparam logic [5:0] OP_SEI  = 6'd37;
    localparam logic [5:0] OP_TYA  = 6'd38;
    localparam logic [5:0] OP_CLV  = 6'd39;
    localparam logic [5:0] OP_CLD  = 6'd40;
    localparam logic [5:0] OP_SED  = 6'd41;
    localparam logic [5:0] OP_BRK  = 6'd42;
    localparam logic [5:0] OP_JSR  = 6'd43;
    localparam logic [5:0] OP_RTI  = 6'd44;
    localparam logic [5:0] OP_RTS  = 6'd45;
    localparam logic [5:0] OP_LDY  = 6'd46;
    localparam logic [5:0] OP_CPY  = 6'd47;
    localparam logic [5:0] OP_CPX  = 6'd48;
    localparam logic [5:0] OP_BIT  = 6'd49;
    localparam logic [5:0] OP_STY  = 6'd50;
    localparam logic [5:0] OP_JMP  = 6'd51;
    localparam logic [5:0] OP_BAD  = 6'd52;
    localparam logic [5:0] OP_BR   = 6'd53;

    typedef struct packed {
        logic [3:0] mode;
        logic [5:0] op;
    } dec_t;

    // controller to datapath
    typedef struct packed {
        logic [4:0] step;
        logic [3:0] mode;
        logic [5:0] op;
        logic [7:0] opcode;
        logic       load_in;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic        bad_opcode;
        logic        halted;
        logic [7:0]  flags;
        logic [7:0]  stack_ptr;
        logic [7:0]  index_y;
        logic [7:0]  index_x;
        logic [7:0]  accumulator;
        logic [15:0] prog_counter;
        logic [7:0]  read_byte;
    } res_t;

    function automatic dec_t c6502_decode(input logic [7:0] opc);
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        dec_t d;
        aaa = opc[7:5];
        bbb = opc[4:2];
        cc = opc[1:0];
        d.mode = M_IMP;
        d.op = OP_BAD;
        unique case (cc)
            2'd1: begin
                if (opc != 8'h89) begin
                    d.op = {3'b000, aaa};
                    unique case (bbb)
                        3'd0: d.mode = M_IZX;
                        3'd1: d.mode = M_ZP;
                        3'd2: d.mode = M_IMM;
                        3'd3: d.mode = M_ABS;
                        3'd4: d.mode = M_IZY;
                        3'd5: d.mode = M_ZPX;
                        3'd6: d.mode = M_ABY;
                        default: d.mode = M_ABX;
                    endcase
                end
            end
            2'd2: begin
                if (bbb == 3'd2) begin
                    d.op = 6'(aaa) + 6'd16;
                end else if (bbb == 3'd6) begin
                    if (aaa == 3'd4) d.op = OP_TXS;
                    else if (aaa == 3'd5) d.op = OP_TSX;
                end else if (!(bbb == 3'd4 || (bbb == 3'd0 && aaa != 3'd5)
                               || (bbb == 3'd7 && aaa == 3'd4))) begin
                    d.op = (aaa >= 3'd4) ? 6'(aaa) + 6'd4 : 6'(aaa) + 6'd12;
                    unique case (bbb)
                        3'd0: d.mode = M_IMM;
                        3'd1: d.mode = M_ZP;
                        3'd3: d.mode = M_ABS;
                        3'd5: d.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
                        default: d.mode = (aaa == 3'd5) ? M_ABY : M_ABX;
                    endcase
                end
            end
            2'd0: begin
                if (bbb == 3'd4) begin
                    d.mode = M_REL;
                    d.op = OP_BR;
                end else if (bbb == 3'd2) begin
                    d.op = 6'(aaa) + 6'd26;
                end else if (bbb == 3'd6) begin
                    d.op = 6'(aaa) + 6'd34;
                end else if (bbb == 3'd0) begin
                    if (aaa == 3'd1) begin
                        d.mode = M_JSR;
                        d.op = OP_JSR;
                    end else if (aaa <= 3'd3) begin
                        d.op = 6'(aaa) + 6'd42;
                    end else if (aaa >= 3'd5) begin
                        d.mode = M_IMM;
                        d.op = 6'(aaa) + 6'd41;
                    end
                end else if (opc == 8'h4C) begin
                    d.mode = M_JMP;
                    d.op = OP_JMP;
                end else if (opc == 8'h6C) begin
                    d.mode = M_JIND;
                    d.op = OP_JMP;
                end else if ((aaa == 3'd1 && (bbb == 3'd1 || bbb == 3'd3))
                             || (aaa == 3'd4 && bbb != 3'd7) || aaa == 3'd5
                             || ((aaa == 3'd6 || aaa == 3'd7)
                                 && (bbb == 3'd1 || bbb == 3'd3))) begin
                    unique case (aaa)
                        3'd1: d.op = OP_BIT;
                        3'd4: d.op = OP_STY;
                        3'd5: d.op = OP_LDY;
                        3'd6: d.op = OP_CPY;
                        default: d.op = OP_CPX;
                    endcase
                    unique case (bbb)
                        3'd1: d.mode = M_ZP;
                        3'd3: d.mode = M_ABS;
                        3'd5: d.mode = M_ZPX;
                        default: d.mode = M_ABX;
                    endcase
                end
            end
            default: ;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/c6502_ram.sv
// generic single-port ram with registered read data
// standalone, no package needed
`timescale 1ns / 1ps
`default_nettype none
module c6502_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/c6502_ctrl.sv
// sequencer of the 6502 instruction core: request handshake, opcode decode,
// step order per addressing mode; uses c6502_pkg
`timescale 1ns / 1ps
`default_nettype none
module c6502_ctrl import c6502_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [1:0] s_kind,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] mem_rdata,
    input  wire logic       halted,
    output cmd_t            cmd
);
    logic [4:0] state_reg, state_next;
    logic [3:0] mode_reg, mode_next;
    logic [5:0] op_reg, op_next;
    logic [7:0] opcode_reg, opcode_next;
    logic       m_valid_reg, m_valid_next;
    logic       fire_in;
    logic       out_load;
    dec_t       dec_now;

    assign dec_now  = c6502_decode(mem_rdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign fire_in  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd.step     = state_reg;
        cmd.mode     = (state_reg == ST_DEC) ? dec_now.mode : mode_reg;
        cmd.op       = (state_reg == ST_DEC) ? dec_now.op : op_reg;
        cmd.opcode   = (state_reg == ST_DEC) ? mem_rdata : opcode_reg;
        cmd.load_in  = fire_in;
        cmd.out_load = out_load;
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        op_next     = op_reg;
        opcode_next = opcode_reg;
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (fire_in) begin
                    unique case (s_kind)
                        KIND_WRITE: state_next = ST_MWR;
                        KIND_READ:  state_next = ST_MRD;
                        KIND_RESET: state_next = ST_RV0;
                        default:    state_next = halted ? ST_DONE : ST_FETCH;
                    endcase
                end
            end
            ST_MWR:   state_next = ST_DONE;
            ST_MRD:   state_next = ST_MRD2;
            ST_MRD2:  state_next = ST_DONE;
            ST_RV0:   state_next = ST_RV1;
            ST_RV1:   state_next = ST_RV2;
            ST_RV2:   state_next = ST_DONE;
            ST_FETCH: state_next = ST_DEC;
            ST_DEC: begin
                mode_next   = dec_now.mode;
                op_next     = dec_now.op;
                opcode_next = mem_rdata;
                if (dec_now.op == OP_BAD || dec_now.op == OP_BRK) state_next = ST_DONE;
                else if (dec_now.mode == M_IMP) state_next = ST_IMPL;
                else state_next = ST_A1;
            end
            ST_IMPL: begin
                if (op_reg == OP_PLA || op_reg == OP_PLP) state_next = ST_PL2;
                else if (op_reg == OP_RTS) state_next = ST_R1;
                else if (op_reg == OP_RTI) state_next = ST_T1;
                else state_next = ST_DONE;
            end
            ST_PL2: state_next = ST_DONE;
            ST_T1:  state_next = ST_R1;
            ST_R1:  state_next = ST_R2;
            ST_R2:  state_next = ST_DONE;
            ST_A1: begin
                unique case (mode_reg)
                    M_IMM, M_ZP, M_ZPX, M_ZPY: state_next = ST_OPRD;
                    M_IZX, M_IZY:              state_next = ST_I1;
                    M_REL:                     state_next = ST_DONE;
                    default:                   state_next = ST_A2;
                endcase
            end
            ST_A2: begin
                unique case (mode_reg)
                    M_JMP:   state_next = ST_DONE;
                    M_JIND:  state_next = ST_J1;
                    M_JSR:   state_next = ST_JS2;
                    default: state_next = ST_OPRD;
                endcase
            end
            ST_I1:   state_next = ST_I2;
            ST_I2:   state_next = ST_OPRD;
            ST_J1:   state_next = ST_J2;
            ST_J2:   state_next = ST_DONE;
            ST_JS2:  state_next = ST_DONE;
            ST_OPRD: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        op_reg     <= op_next;
        opcode_reg <= opcode_next;
    end

    a_reset_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire_in && s_kind == KIND_RESET) |=> state_reg == ST_RV0)
        else $error("reset request did not start the vector fetch");
    a_fetch_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |=> state_reg == ST_DEC)
        else $error("opcode fetch not followed by decode");
    a_exec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> state_reg == ST_DONE)
        else $error("execute step did not finish the request");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("request taken while busy");
endmodule
`default_nettype wire

### rtl/c6502_dp.sv
// datapath of the 6502 instruction core: registers, alu, address select and
// result register; uses c6502_pkg, driven by c6502_ctrl commands
`timescale 1ns / 1ps
`default_nettype none
module c6502_dp import c6502_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire logic [15:0] s_mem_addr,
    input  wire logic [7:0]  s_write_byte,
    input  wire logic [7:0]  mem_rdata,
    output logic [15:0]      mem_addr,
    output logic             mem_we,
    output logic [7:0]       mem_wdata,
    output logic             halted,
    output res_t             res
);
    logic [15:0] pc_reg, pc_next, ea_reg, ea_next, in_addr_reg, in_addr_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0]  sp_reg, sp_next, p_reg, p_next;
    logic [7:0]  lo_reg, lo_next, ptr_reg, ptr_next, in_data_reg, in_data_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        halt_reg, halt_next, bad_reg, bad_next;
    res_t        res_reg;

    logic [7:0]  alu_a, alu_x, alu_y, alu_sp, alu_p, alu_wd;
    logic        alu_we;
    logic [7:0]  sh_in, sh_r, addend, cmp_reg, cmp_diff, zn_v, d;
    logic        sh_c, zn_en, br_flag;
    logic [8:0]  sum9;
    logic [15:0] full16, stk, stk_up;

    assign d      = mem_rdata;
    assign full16 = {mem_rdata, lo_reg};
    assign stk    = {8'h01, sp_reg};
    assign stk_up = {8'h01, sp_reg + 8'd1};
    assign halted = halt_reg;
    assign res    = res_reg;

    // alu for the operand and implied operations
    always_comb begin
        alu_a = a_reg;
        alu_x = x_reg;
        alu_y = y_reg;
        alu_sp = sp_reg;
        alu_p = p_reg;
        alu_we = 1'b0;
        alu_wd = 8'h00;
        zn_en = 1'b0;
        zn_v = 8'h00;
        sh_in = (cmd.op >= OP_ASLA && cmd.op <= OP_RORA) ? a_reg : d;
        if (!cmd.op[1]) begin
            sh_c = sh_in[7];
            sh_r = {sh_in[6:0], cmd.op[0] & p_reg[FL_C]};
        end else begin
            sh_c = sh_in[0];
            sh_r = {cmd.op[0] & p_reg[FL_C], sh_in[7:1]};
        end
        addend = (cmd.op == OP_SBC) ? ~d : d;
        sum9 = {1'b0, a_reg} + {1'b0, addend} + {8'd0, p_reg[FL_C]};
        cmp_reg = (cmd.op == OP_CPX) ? x_reg : ((cmd.op == OP_CPY) ? y_reg : a_reg);
        cmp_diff = cmp_reg - d;
        case (cmd.op)
            OP_ORA: begin alu_a = a_reg | d; zn_en = 1'b1; zn_v = a_reg | d; end
            OP_AND: begin alu_a = a_reg & d; zn_en = 1'b1; zn_v = a_reg & d; end
            OP_EOR: begin alu_a = a_reg ^ d; zn_en = 1'b1; zn_v = a_reg ^ d; end
            OP_ADC, OP_SBC: begin
                alu_a = sum9[7:0];
                alu_p[FL_C] = sum9[8];
                alu_p[FL_V] = (addend[7] ^ sum9[7]) & (sum9[7] ^ a_reg[7]);
                zn_en = 1'b1;
                zn_v = sum9[7:0];
            end
            OP_STA: begin alu_we = 1'b1; alu_wd = a_reg; end
            OP_STX: begin alu_we = 1'b1; alu_wd = x_reg; end
            OP_STY: begin alu_we = 1'b1; alu_wd = y_reg; end
            OP_LDA, OP_PLA: begin alu_a = d; zn_en = 1'b1; zn_v = d; end
            OP_LDX: begin alu_x = d; zn_en = 1'b1; zn_v = d; end
            OP_LDY: begin alu_y = d; zn_en = 1'b1; zn_v = d; end
            OP_CMP, OP_CPX, OP_CPY: begin
                alu_p[FL_C] = (cmp_reg >= d);
                zn_en = 1'b1;
                zn_v = cmp_diff;
            end
            OP_DEC: begin
                alu_we = 1'b1; alu_wd = d - 8'd1; zn_en = 1'b1; zn_v = d - 8'd1;
            end
            OP_INC: begin
                alu_we = 1'b1; alu_wd = d + 8'd1; zn_en = 1'b1; zn_v = d + 8'd1;
            end
            OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
                alu_we = 1'b1; alu_wd = sh_r; alu_p[FL_C] = sh_c;
                zn_en = 1'b1; zn_v = sh_r;
            end
            OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA: begin
                alu_a = sh_r; alu_p[FL_C] = sh_c; zn_en = 1'b1; zn_v = sh_r;
            end
            OP_BIT: begin
                alu_p[FL_Z] = ((a_reg & d) == 8'h00);
                alu_p[FL_N] = d[7];
                alu_p[FL_V] = d[6];
            end
            OP_TXA: begin alu_a = x_reg; zn_en = 1'b1; zn_v = x_reg; end
            OP_TYA: begin alu_a = y_reg; zn_en = 1'b1; zn_v = y_reg; end
            OP_TAX: begin alu_x = a_reg; zn_en = 1'b1; zn_v = a_reg; end
            OP_TAY: begin alu_y = a_reg; zn_en = 1'b1; zn_v = a_reg; end
            OP_TSX: begin alu_x = sp_reg; zn_en = 1'b1; zn_v = sp_reg; end
            OP_TXS: alu_sp = x_reg;
            OP_DEX: begin alu_x = x_reg - 8'd1; zn_en = 1'b1; zn_v = x_reg - 8'd1; end
            OP_INX: begin alu_x = x_reg + 8'd1; zn_en = 1'b1; zn_v = x_reg + 8'd1; end
            OP_DEY: begin alu_y = y_reg - 8'd1; zn_en = 1'b1; zn_v = y_reg - 8'd1; end
            OP_INY: begin alu_y = y_reg + 8'd1; zn_en = 1'b1; zn_v = y_reg + 8'd1; end
            // pushed status carries both break bits
            OP_PHP: begin alu_we = 1'b1; alu_wd = p_reg | 8'h30; alu_sp = sp_reg - 8'd1; end
            OP_PHA: begin alu_we = 1'b1; alu_wd = a_reg; alu_sp = sp_reg - 8'd1; end
            OP_PLP: alu_p = (d & 8'hEF) | 8'h20;
            OP_CLC: alu_p[FL_C] = 1'b0;
            OP_SEC: alu_p[FL_C] = 1'b1;
            OP_CLI: alu_p[FL_I] = 1'b0;
            OP_SEI: alu_p[FL_I] = 1'b1;
            OP_CLV: alu_p[FL_V] = 1'b0;
            OP_CLD: alu_p[FL_D] = 1'b0;
            OP_SED: alu_p[FL_D] = 1'b1;
            default: ;
        endcase
        if (zn_en) begin
            alu_p[FL_Z] = (zn_v == 8'h00);
            alu_p[FL_N] = zn_v[7];
        end
    end

    // branch flag picked by opcode bits 7:6, wanted value in bit 5
    always_comb begin
        case (cmd.opcode[7:6])
            2'd0: br_flag = p_reg[FL_N];
            2'd1: br_flag = p_reg[FL_V];
            2'd2: br_flag = p_reg[FL_C];
            default: br_flag = p_reg[FL_Z];
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        sp_next = sp_reg;
        p_next = p_reg;
        halt_next = halt_reg;
        bad_next = bad_reg;
        rbyte_next = rbyte_reg;
        lo_next = lo_reg;
        ptr_next = ptr_reg;
        ea_next = ea_reg;
        in_addr_next = in_addr_reg;
        in_data_next = in_data_reg;
        mem_addr = pc_reg;
        mem_we = 1'b0;
        mem_wdata = 8'h00;
        unique case (cmd.step)
            ST_IDLE: begin
                if (cmd.load_in) begin
                    in_addr_next = s_mem_addr;
                    in_data_next = s_write_byte;
                    bad_next = 1'b0;
                    rbyte_next = 8'h00;
                end
            end
            ST_MWR: begin
                mem_addr = in_addr_reg;
                mem_we = 1'b1;
                mem_wdata = in_data_reg;
            end
            ST_MRD:  mem_addr = in_addr_reg;
            ST_MRD2: rbyte_next = mem_rdata;
            ST_RV0:  mem_addr = RESET_VEC;
            ST_RV1: begin
                lo_next = mem_rdata;
                mem_addr = RESET_VEC + 16'd1;
            end
            ST_RV2: begin
                pc_next = full16;
                a_next = 8'h00;
                x_next = 8'h00;
                p_next = 8'h00;
                halt_next = 1'b0;
            end
            ST_FETCH: mem_addr = pc_reg;
            ST_DEC: begin
                mem_addr = pc_reg + 16'd1;
                pc_next = pc_reg + 16'd1;
                if (cmd.op == OP_BRK) halt_next = 1'b1;
                if (cmd.op == OP_BAD) bad_next = 1'b1;
            end
            ST_A1: begin
                mem_addr = pc_reg + 16'd1;
                unique case (cmd.mode)
                    M_IMM: begin ea_next = pc_reg; pc_next = pc_reg + 16'd1; end
                    M_ZP:  begin ea_next = {8'h00, d}; pc_next = pc_reg + 16'd1; end
                    M_ZPX: begin ea_next = {8'h00, d + x_reg}; pc_next = pc_reg + 16'd1; end
                    M_ZPY: begin ea_next = {8'h00, d + y_reg}; pc_next = pc_reg + 16'd1; end
                    M_IZX: begin
                        ptr_next = d + x_reg;
                        mem_addr = {8'h00, d + x_reg};
                        pc_next = pc_reg + 16'd1;
                    end
                    M_IZY: begin
                        ptr_next = d;
                        mem_addr = {8'h00, d};
                        pc_next = pc_reg + 16'd1;
                    end
                    M_REL: begin
                        if (br_flag == cmd.opcode[5]) begin
                            pc_next = pc_reg + 16'd1 + {{8{d[7]}}, d};
                        end else begin
                            pc_next = pc_reg + 16'd1;
                        end
                    end
                    default: lo_next = d;
                endcase
            end
            ST_A2: begin
                unique case (cmd.mode)
                    M_ABS: begin ea_next = full16; pc_next = pc_reg + 16'd2; end
                    M_ABX: begin ea_next = full16 + {8'h00, x_reg}; pc_next = pc_reg + 16'd2; end
                    M_ABY: begin ea_next = full16 + {8'h00, y_reg}; pc_next = pc_reg + 16'd2; end
                    M_JMP: pc_next = full16;
                    M_JIND: begin ea_next = full16; mem_addr = full16; end
                    default: begin
                        // jsr: push high byte of the return address
                        ea_next = full16;
                        mem_addr = stk;
                        mem_we = 1'b1;
                        mem_wdata = 8'((pc_reg + 16'd1) >> 8);
                        sp_next = sp_reg - 8'd1;
                    end
                endcase
            end
            ST_I1: begin
                lo_next = mem_rdata;
                mem_addr = {8'h00, ptr_reg + 8'd1};
            end
            ST_I2: begin
                ea_next = (cmd.mode == M_IZY) ? full16 + {8'h00, y_reg} : full16;
            end
            ST_J1: begin
                lo_next = mem_rdata;
                mem_addr = {ea_reg[15:8], ea_reg[7:0] + 8'd1};
            end
            ST_J2: pc_next = full16;
            ST_JS2: begin
                mem_addr = stk;
                mem_we = 1'b1;
                mem_wdata = pc_reg[7:0] + 8'd1;
                sp_next = sp_reg - 8'd1;
                pc_next = ea_reg;
            end
            ST_OPRD: mem_addr = ea_reg;
            ST_EXEC, ST_PL2: begin
                mem_addr = ea_reg;
                mem_we = alu_we;
                mem_wdata = alu_wd;
                a_next = alu_a;
                x_next = alu_x;
                y_next = alu_y;
                sp_next = alu_sp;
                p_next = alu_p;
            end
            ST_IMPL: begin
                if (cmd.op == OP_PLA || cmd.op == OP_PLP || cmd.op == OP_RTS
                    || cmd.op == OP_RTI) begin
                    sp_next = sp_reg + 8'd1;
                    mem_addr = stk_up;
                end else begin
                    mem_addr = stk;
                    mem_we = alu_we;
                    mem_wdata = alu_wd;
                    a_next = alu_a;
                    x_next = alu_x;
                    y_next = alu_y;
                    sp_next = alu_sp;
                    p_next = alu_p;
                end
            end
            ST_T1: begin
                p_next = (mem_rdata & 8'hEF) | 8'h20;
                sp_next = sp_reg + 8'd1;
                mem_addr = stk_up;
            end
            ST_R1: begin
                lo_next = mem_rdata;
                sp_next = sp_reg + 8'd1;
                mem_addr = stk_up;
            end
            ST_R2: pc_next = (cmd.op == OP_RTS) ? full16 + 16'd1 : full16;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= 16'h0000;
            a_reg    <= 8'h00;
            x_reg    <= 8'h00;
            y_reg    <= 8'h00;
            sp_reg   <= 8'h00;
            p_reg    <= 8'h00;
            halt_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            a_reg    <= a_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            sp_reg   <= sp_next;
            p_reg    <= p_next;
            halt_reg <= halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bad_reg     <= bad_next;
        rbyte_reg   <= rbyte_next;
        lo_reg      <= lo_next;
        ptr_reg     <= ptr_next;
        ea_reg      <= ea_next;
        in_addr_reg <= in_addr_next;
        in_data_reg <= in_data_next;
        if (cmd.out_load) begin
            res_reg.read_byte    <= rbyte_reg;
            res_reg.prog_counter <= pc_reg;
            res_reg.accumulator  <= a_reg;
            res_reg.index_x      <= x_reg;
            res_reg.index_y      <= y_reg;
            res_reg.stack_ptr    <= sp_reg;
            res_reg.flags        <= p_reg;
            res_reg.halted       <= halt_reg;
            res_reg.bad_opcode   <= bad_reg;
        end
    end
endmodule
`default_nettype wire

### rtl/cpu_6502_instruction_core.sv
// 6502-style instruction core with private byte memory (binary arithmetic only)
// s_tuser[1:0] is the request kind: write byte, read byte, reset, execute.
// s_tdata carries mem_addr and write_byte; a request is taken when s_tvalid
// and s_tready are high at a rising edge of aclk.
// every request returns one result on the m_ side: read byte (zero unless a
// read request), pc, a, x, y, sp, status, halted and bad opcode.
// how long a request takes from accept to m_tvalid follows the number of reads
// and writes of the instruction: one single-port memory access per cycle with
// registered read data (indexed indirect and indirect indexed modes are the
// longest and an execute while halted the shortest).
// one request is worked on at a time; the core is ready for the next one once
// the result register loads, while that result waits for m_tready.
// a stalled receiver holds the finished request in its last step until the
// result register frees up, then the core goes back to taking requests.
// aresetn clears all cpu registers and the halt flag; memory keeps no reset
// value and must be written before it is read. a reset request loads pc from
// the vector at 0xfffc and clears a, x and the status byte.
// brk sets halted, after which execute requests change nothing until a reset
// request.
`timescale 1ns / 1ps
`default_nettype none
module cpu_6502_instruction_core import c6502_pkg::*; #(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // mem_addr[15:0], write_byte[23:16]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // read_byte, prog_counter, accumulator, index_x,
                                        // index_y, stack_ptr, flags, halted, bad_opcode
);
    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);

    cmd_t        cmd;
    res_t        res;
    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic [7:0]  mem_rdata;
    logic        halted;

    c6502_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .mem_rdata (mem_rdata),
        .halted    (halted),
        .cmd       (cmd)
    );

    c6502_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_mem_addr   (s_tdata[15:0]),
        .s_write_byte (s_tdata[23:16]),
        .mem_rdata    (mem_rdata),
        .mem_addr     (mem_addr),
        .mem_we       (mem_we),
        .mem_wdata    (mem_wdata),
        .halted       (halted),
        .res          (res)
    );

    // addresses wrap modulo the memory size
    c6502_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_tdata = {6'd0, res.bad_opcode, res.halted, res.flags, res.stack_ptr,
                      res.index_y, res.index_x, res.accumulator, res.prog_counter,
                      res.read_byte};
endmodule
`default_nettype wire

### verif/cpu_6502_core_checker.sv
// result checker for the 6502 instruction core: watches both stream channels,
// predicts each result from its own copy of the core state and compares
// depends on c6502_pkg for the result layout and the code constants
`timescale 1ns / 1ps
module cpu_6502_core_checker import c6502_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // mem_addr[15:0], write_byte[23:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // read_byte, prog_counter, accumulator, index_x,
                                   // index_y, stack_ptr, flags, halted, bad_opcode
    output int          fail_count,
    output int          pending
);

    logic [7:0]  mem [0:65535];
    bit          written [0:65535];
    bit          probing;
    bit          probe_miss;
    logic [15:0] probe_addr;
    logic [15:0] pc;
    logic [7:0]  acc, xr, yr, sp, st;
    logic        halt;
    res_t        result_queue[$];

    // notes the first byte read that was never written
    function automatic logic [7:0] rd(input logic [15:0] a);
        if (!written[a] && !probe_miss) begin
            probe_miss = 1'b1;
            probe_addr = a;
        end
        return mem[a];
    endfunction

    // a dry run leaves memory untouched
    function automatic void wr(input logic [15:0] a, input logic [7:0] v);
        if (!probing) begin
            mem[a] = v;
            written[a] = 1'b1;
        end
    endfunction

    function automatic logic [15:0] rd16(input logic [15:0] a);
        return {rd(a + 16'd1), rd(a)};
    endfunction

    function automatic void put_flag(input int unsigned pos, input logic on);
        st[pos] = on;
    endfunction

    function automatic void set_zn(input logic [7:0] v);
        st[FL_Z] = (v == 8'd0);
        st[FL_N] = v[7];
    endfunction

    function automatic void set_acc(input logic [7:0] v);
        acc = v;
        set_zn(v);
    endfunction

    function automatic void push(input logic [7:0] v);
        wr({8'h01, sp}, v);
        sp = sp - 8'd1;
    endfunction

    function automatic logic [7:0] pull();
        sp = sp + 8'd1;
        return rd({8'h01, sp});
    endfunction

    function automatic void add_acc(input logic [7:0] d);
        logic [8:0] sum;
        sum = {1'b0, acc} + {1'b0, d} + {8'd0, st[FL_C]};
        st[FL_C] = sum[8];
        st[FL_V] = ((d ^ sum[7:0]) & (sum[7:0] ^ acc) & 8'h80) != 8'd0;
        set_acc(sum[7:0]);
    endfunction

    function automatic void compare(input logic [7:0] r, input logic [7:0] d);
        st[FL_C] = (r >= d);
        set_zn(r - d);
    endfunction

    // 0 asl, 1 rol, 2 lsr, 3 ror
    function automatic logic [7:0] shift(input logic [2:0] k, input logic [7:0] v);
        logic       cin;
        logic [7:0] r;
        cin = st[FL_C];
        if (k < 3'd2) begin
            st[FL_C] = v[7];
            r = {v[6:0], (k == 3'd1) ? cin : 1'b0};
        end else begin
            st[FL_C] = v[0];
            r = {(k == 3'd3) ? cin : 1'b0, v[7:1]};
        end
        set_zn(r);
        return r;
    endfunction

    function automatic logic [15:0] eff_addr(input logic [3:0] m, input logic [15:0] p);
        logic [7:0] b;
        case (m)
            M_IMM: return p;
            M_ZP:  return {8'd0, rd(p)};
            M_ZPX: return {8'd0, rd(p) + xr};
            M_ZPY: return {8'd0, rd(p) + yr};
            M_ABS: return rd16(p);
            M_ABX: return rd16(p) + {8'd0, xr};
            M_ABY: return rd16(p) + {8'd0, yr};
            M_IZX: begin
                b = rd(p) + xr;
                return {rd({8'd0, b + 8'd1}), rd({8'd0, b})};
            end
            default: begin
                b = rd(p);
                return {rd({8'd0, b + 8'd1}), rd({8'd0, b})} + {8'd0, yr};
            end
        endcase
    endfunction

    function automatic logic [15:0] next_pc(input logic [3:0] m, input logic [15:0] p);
        return p + ((m == M_ABS || m == M_ABX || m == M_ABY) ? 16'd2 : 16'd1);
    endfunction

    // returns 1 for an undocumented opcode
    function automatic logic run_instruction();
        logic [7:0]  op, v, off;
        logic [15:0] p, a, ptr, t;
        logic [2:0]  aaa, bbb;
        logic [1:0]  cc;
        logic [3:0]  m;
        logic        fl;
        op = rd(pc);
        p = pc + 16'd1;
        aaa = op[7:5];
        bbb = op[4:2];
        cc = op[1:0];
        pc = p;
        if (cc == 2'd1) begin
            if (op == 8'h89) return 1'b1;
            case (bbb)
                3'd0: m = M_IZX;
                3'd1: m = M_ZP;
                3'd2: m = M_IMM;
                3'd3: m = M_ABS;
                3'd4: m = M_IZY;
                3'd5: m = M_ZPX;
                3'd6: m = M_ABY;
                default: m = M_ABX;
            endcase
            a = eff_addr(m, p);
            pc = next_pc(m, p);
            case (aaa)
                3'd0: set_acc(acc | rd(a));
                3'd1: set_acc(acc & rd(a));
                3'd2: set_acc(acc ^ rd(a));
                3'd3: add_acc(rd(a));
                3'd4: wr(a, acc);
                3'd5: set_acc(rd(a));
                3'd6: compare(acc, rd(a));
                default: add_acc(rd(a) ^ 8'hFF);
            endcase
            return 1'b0;
        end
        if (cc == 2'd2) begin
            if (bbb == 3'd2) begin
                case (aaa)
                    3'd4: set_acc(xr);
                    3'd5: begin xr = acc; set_zn(xr); end
                    3'd6: begin xr = xr - 8'd1; set_zn(xr); end
                    3'd7: ;
                    default: set_acc(shift(aaa, acc));
                endcase
                return 1'b0;
            end
            if (bbb == 3'd6) begin
                if (aaa == 3'd4) begin sp = xr; return 1'b0; end
                if (aaa == 3'd5) begin xr = sp; set_zn(xr); return 1'b0; end
                return 1'b1;
            end
            if (bbb == 3'd4 || (bbb == 3'd0 && aaa != 3'd5) || (bbb == 3'd7 && aaa == 3'd4))
                return 1'b1;
            if (bbb == 3'd0) m = M_IMM;
            else if (bbb == 3'd1) m = M_ZP;
            else if (bbb == 3'd3) m = M_ABS;
            else if (bbb == 3'd5) m = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
            else m = (aaa == 3'd5) ? M_ABY : M_ABX;
            a = eff_addr(m, p);
            pc = next_pc(m, p);
            case (aaa)
                3'd4: wr(a, xr);
                3'd5: begin xr = rd(a); set_zn(xr); end
                3'd6: begin v = rd(a) - 8'd1; wr(a, v); set_zn(v); end
                3'd7: begin v = rd(a) + 8'd1; wr(a, v); set_zn(v); end
                default: wr(a, shift(aaa, rd(a)));
            endcase
            return 1'b0;
        end
        if (cc == 2'd3) return 1'b1;

        if (bbb == 3'd4) begin
            off = rd(p);
            case (aaa[2:1])
                2'd0: fl = st[FL_N];
                2'd1: fl = st[FL_V];
                2'd2: fl = st[FL_C];
                default: fl = st[FL_Z];
            endcase
            t = p + 16'd1 + {{8{off[7]}}, off};
            pc = (fl == aaa[0]) ? t : p + 16'd1;
            return 1'b0;
        end
        if (bbb == 3'd2) begin
            case (aaa)
                3'd0: push(st | 8'h30);
                3'd1: st = (pull() & 8'hEF) | 8'h20;
                3'd2: push(acc);
                3'd3: set_acc(pull());
                3'd4: begin yr = yr - 8'd1; set_zn(yr); end
                3'd5: begin yr = acc; set_zn(yr); end
                3'd6: begin yr = yr + 8'd1; set_zn(yr); end
                default: begin xr = xr + 8'd1; set_zn(xr); end
            endcase
            return 1'b0;
        end
        if (bbb == 3'd6) begin
            case (aaa)
                3'd0: put_flag(FL_C, 1'b0);
                3'd1: put_flag(FL_C, 1'b1);
                3'd2: put_flag(FL_I, 1'b0);
                3'd3: put_flag(FL_I, 1'b1);
                3'd4: set_acc(yr);
                3'd5: put_flag(FL_V, 1'b0);
                3'd6: put_flag(FL_D, 1'b0);
                default: put_flag(FL_D, 1'b1);
            endcase
            return 1'b0;
        end
        if (bbb == 3'd0) begin
            case (aaa)
                3'd0: begin halt = 1'b1; return 1'b0; end
                3'd1: begin
                    t = p + 16'd1;
                    push(t[15:8]);
                    push(t[7:0]);
                    pc = rd16(p);
                    return 1'b0;
                end
                3'd2: begin
                    st = (pull() & 8'hEF) | 8'h20;
                    pc[7:0] = pull();
                    pc[15:8] = pull();
                    return 1'b0;
                end
                3'd3: begin
                    t[7:0] = pull();
                    t[15:8] = pull();
                    pc = t + 16'd1;
                    return 1'b0;
                end
                3'd4: return 1'b1;
                default: ;
            endcase
            v = rd(p);
            pc = p + 16'd1;
            if (aaa == 3'd5) begin yr = v; set_zn(v); end
            else compare((aaa == 3'd6) ? yr : xr, v);
            return 1'b0;
        end
        if (op == 8'h4C) begin pc = rd16(p); return 1'b0; end
        if (op == 8'h6C) begin
            // pointer high byte stays in the same page
            ptr = rd16(p);
            pc = {rd({ptr[15:8], ptr[7:0] + 8'd1}), rd(ptr)};
            return 1'b0;
        end
        if (aaa == 3'd1) begin
            if (bbb != 3'd1 && bbb != 3'd3) return 1'b1;
        end else if (aaa == 3'd4) begin
            if (bbb == 3'd7) return 1'b1;
        end else if (aaa == 3'd6 || aaa == 3'd7) begin
            if (bbb != 3'd1 && bbb != 3'd3) return 1'b1;
        end else if (aaa != 3'd5) begin
            return 1'b1;
        end
        m = (bbb == 3'd1) ? M_ZP : (bbb == 3'd3) ? M_ABS : (bbb == 3'd5) ? M_ZPX : M_ABX;
        a = eff_addr(m, p);
        pc = next_pc(m, p);
        case (aaa)
            3'd1: begin
                v = rd(a);
                st[FL_Z] = ((acc & v) == 8'd0);
                st[FL_N] = v[7];
                st[FL_V] = v[6];
            end
            3'd4: wr(a, yr);
            3'd5: begin yr = rd(a); set_zn(yr); end
            3'd6: compare(yr, rd(a));
            default: compare(xr, rd(a));
        endcase
        return 1'b0;
    endfunction

    // dry run of the next execute request on the current state; returns 1 and
    // the address when it would read a byte that was never written
    function automatic bit probe_exec(output logic [15:0] addr);
        logic [15:0] s_pc;
        logic [7:0]  s_acc, s_xr, s_yr, s_sp, s_st;
        logic        s_halt;
        s_pc = pc;
        s_acc = acc;
        s_xr = xr;
        s_yr = yr;
        s_sp = sp;
        s_st = st;
        s_halt = halt;
        probing = 1'b1;
        probe_miss = 1'b0;
        probe_addr = '0;
        if (!halt) void'(run_instruction());
        probing = 1'b0;
        pc = s_pc;
        acc = s_acc;
        xr = s_xr;
        yr = s_yr;
        sp = s_sp;
        st = s_st;
        halt = s_halt;
        addr = probe_addr;
        return probe_miss;
    endfunction

    function automatic res_t predict_result(input logic [1:0] kind, input logic [15:0] addr,
                                            input logic [7:0] wb);
        res_t r;
        r = '0;
        case (kind)
            KIND_WRITE: wr(addr, wb);
            KIND_READ:  r.read_byte = rd(addr);
            KIND_RESET: begin
                acc = 8'd0;
                xr = 8'd0;
                st = 8'd0;
                halt = 1'b0;
                pc = rd16(RESET_VEC);
            end
            default: if (!halt) r.bad_opcode = run_instruction();
        endcase
        r.prog_counter = pc;
        r.accumulator = acc;
        r.index_x = xr;
        r.index_y = yr;
        r.stack_ptr = sp;
        r.flags = st;
        r.halted = halt;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
        end
    endtask

    initial begin
        fail_count = 0;
        probing = 1'b0;
        probe_miss = 1'b0;
        probe_addr = '0;
        pc = '0; acc = '0; xr = '0; yr = '0; sp = '0; st = '0; halt = 1'b0;
    end

    assign pending = result_queue.size();

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                result_queue.push_back(predict_result(s_tuser, s_tdata[15:0], s_tdata[23:16]));
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = result_queue.pop_front();
                    report_field("read_byte", want.read_byte, got.read_byte);
                    report_field("prog_counter", want.prog_counter, got.prog_counter);
                    report_field("accumulator", want.accumulator, got.accumulator);
                    report_field("index_x", want.index_x, got.index_x);
                    report_field("index_y", want.index_y, got.index_y);
                    report_field("stack_ptr", want.stack_ptr, got.stack_ptr);
                    report_field("flags", want.flags, got.flags);
                    report_field("halted", want.halted, got.halted);
                    report_field("bad_opcode", want.bad_opcode, got.bad_opcode);
                end
            end
        end
    end

endmodule

### verif/cpu_6502_instruction_core_tb.sv
// top of the 6502 instruction core testbench: clock, reset, request stimulus,
// result back-pressure and verdict; depends on c6502_pkg and cpu_6502_core_checker
`timescale 1ns / 1ps
module cpu_6502_instruction_core_tb import c6502_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // mem_addr[15:0], write_byte[23:16]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // read_byte, prog_counter, accumulator, index_x,
                            // index_y, stack_ptr, flags, halted, bad_opcode
    int          fail_count;
    int          pending;
    int          sent;
    bit          gaps_on;
    bit          stall_done;

    cpu_6502_instruction_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cpu_6502_core_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at a falling edge, once a rising edge has taken the request
    task automatic send_request(input logic [1:0] kind, input logic [15:0] addr,
                                input logic [7:0] wb);
        int  gap;
        bit  rdy;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {wb, addr};
        forever begin
            #1 rdy = s_tready;
            @(posedge aclk);
            if (rdy) break;
            @(negedge aclk);
        end
        sent++;
        @(negedge aclk);
    endtask

    // bytes the next instruction would read get a value first
    task automatic send_exec();
        logic [15:0] miss_addr;
        while (checker_i.probe_exec(miss_addr))
            send_request(KIND_WRITE, miss_addr, 8'($urandom));
        send_request(KIND_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // mostly documented opcode groups, sometimes any byte
    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        op = 8'($urandom);
        if ($urandom_range(0, 4) != 0) op[1:0] = 2'($urandom_range(0, 2));
        return op;
    endfunction

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!stall_done && sent > 900) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (gaps_on && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [15:0] base;
        int          n;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_WRITE;
        aresetn = 1'b0;
        sent = 0;
        gaps_on = 1'b0;
        stall_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        gaps_on = 1'b1;

        send_request(KIND_WRITE, 16'h0000, 8'hFF);
        send_request(KIND_READ, 16'h0000, 8'h00);
        send_request(KIND_WRITE, 16'hFFFF, 8'h00);
        send_request(KIND_READ, 16'hFFFF, 8'hFF);
        send_request(KIND_WRITE, 16'hFFFC, 8'h00);
        send_request(KIND_WRITE, 16'hFFFD, 8'h02);
        // lda #7f, adc #01 overflows, sbc #80, jmp (02ff) with page wrap
        send_request(KIND_WRITE, 16'h0200, 8'hA9);
        send_request(KIND_WRITE, 16'h0201, 8'h7F);
        send_request(KIND_WRITE, 16'h0202, 8'h69);
        send_request(KIND_WRITE, 16'h0203, 8'h01);
        send_request(KIND_WRITE, 16'h0204, 8'hE9);
        send_request(KIND_WRITE, 16'h0205, 8'h80);
        send_request(KIND_WRITE, 16'h0206, 8'h6C);
        send_request(KIND_WRITE, 16'h0207, 8'hFF);
        send_request(KIND_WRITE, 16'h0208, 8'h02);
        send_request(KIND_WRITE, 16'h02FF, 8'h10);
        send_request(KIND_WRITE, 16'hA910, 8'h00);
        send_request(KIND_RESET, 16'hFFFF, 8'hFF);
        repeat (4) send_exec();
        // brk, then execute while halted
        send_exec();
        send_exec();

        // short programs at random places, started through the reset vector
        while (sent < 1880) begin
            base = 16'($urandom);
            if ($urandom_range(0, 9) == 0) base = 16'hFFFE;
            n = $urandom_range(1, 6);
            send_request(KIND_WRITE, RESET_VEC, base[7:0]);
            send_request(KIND_WRITE, RESET_VEC + 16'd1, base[15:8]);
            for (int k = 0; k < n; k++) begin
                send_request(KIND_WRITE, base + 16'(3 * k), pick_opcode());
                send_request(KIND_WRITE, base + 16'(3 * k + 1), 8'($urandom));
                send_request(KIND_WRITE, base + 16'(3 * k + 2), 8'($urandom));
            end
            send_request(KIND_RESET, 16'($urandom), 8'($urandom));
            for (int k = 0; k < n + 2; k++) begin
                case ($urandom_range(0, 9))
                    0: send_request(KIND_READ, base + 16'($urandom_range(0, 3 * n - 1)),
                                    8'($urandom));
                    1: send_request(KIND_WRITE, 16'($urandom), 8'($urandom));
                    default: send_exec();
                endcase
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
